/* rtl/roi_vote_hysteresis_core_assert.svh */
// assertion macros for the zone vote filter
`ifndef ROI_VOTE_HYSTERESIS_CORE_ASSERT_SVH
`define ROI_VOTE_HYSTERESIS_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RVH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define RVH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rvh_pkg.sv */
package rvh_pkg;

    localparam int RVH_HISTORY_DEPTH = 15;
    localparam int RVH_ZONE_COUNT    = 16;

    localparam int ROI_W  = 5;
    localparam int ZONE_W = 4;
    localparam int TIME_W = 48;

    // highest zone the roi field can carry
    localparam int ROI_MAX = 15;

    localparam logic [1:0] REQ_FRAME  = 2'd0;
    localparam logic [1:0] REQ_NOTIFY = 2'd1;
    localparam logic [1:0] REQ_RESET  = 2'd2;

    localparam logic EV_ENTRY  = 1'b0;
    localparam logic EV_DEPART = 1'b1;

    localparam logic signed [ROI_W-1:0] VOTE_NONE = -5'sd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    // floor(x/5) for x below 256, by reciprocal multiply
    function automatic logic [7:0] div5(input logic [7:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return p[17:10];
    endfunction

endpackage

/* rtl/roi_vote_hysteresis_core.sv */
// Per-track zone vote filter with hysteresis.
// Input channel (i_in_valid / o_in_ready) takes one request: a frame
// observation, a mark-notified or a track reset. Output channel
// (o_out_valid / i_out_ready) carries at most one entry or departure event
// per observation, held in an output register until taken.
// Mark-notified, reset and unused request codes complete in the accept
// cycle and leave ready high, so they can follow back to back.
// A frame observation pushes its vote into the history, then one shared
// tally incrementer walks the history one entry a cycle through the
// registered history read port, with a decision cycle at the end.
// An observation holds ready low through the scan and the decision step,
// so the next request is taken only once it is through; the event is
// loaded into the output register by the decision step and is visible
// in the cycle after the decision.
// Reset (i_rst_n low, synchronous) empties the history, sets the stable
// zone to none and clears the notified mark, entry time and output valid.
// If the receiver stalls with an event still held, the next event waits in
// the decision step and no new request is taken until it can be loaded.
module roi_vote_hysteresis_core
    import rvh_pkg::*;
#(
    parameter int HISTORY_DEPTH = RVH_HISTORY_DEPTH,
    parameter int ZONE_COUNT    = RVH_ZONE_COUNT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic signed [ROI_W-1:0] i_frame_roi,
    input  logic                    i_is_vehicle,
    input  logic [TIME_W-1:0]       i_now_ms,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_event_kind,
    output logic [ZONE_W-1:0]       o_zone_index,
    output logic [TIME_W-1:0]       o_entry_time_ms
);

    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    // tally slots: none first, then each zone the roi field can reach
    localparam int NSLOT  = ((ZONE_COUNT < ROI_MAX + 1) ? ZONE_COUNT : ROI_MAX + 1) + 1;
    localparam int SLOT_W = $clog2(NSLOT);

    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] WP_LAST  = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [IDX_W-1:0] WP_ONE   = (HISTORY_DEPTH > 1) ? IDX_W'(1) : '0;
    localparam logic [6:0]       ZC       = 7'(ZONE_COUNT);

    t_state r_state, n_state;

    logic signed [ROI_W-1:0] r_hist [HISTORY_DEPTH];
    logic [CNT_W-1:0]        r_cnt  [NSLOT];

    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_wp, n_wp;
    logic signed [ROI_W-1:0] r_stable, n_stable;
    logic                    r_notified, n_notified;
    logic [TIME_W-1:0]       r_entry, n_entry;

    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_need, n_need;
    logic signed [ROI_W-1:0] r_prev, n_prev;
    logic                    r_vehicle, n_vehicle;
    logic [TIME_W-1:0]       r_now, n_now;
    logic [SLOT_W-1:0]       r_best, n_best;
    logic                    r_found, n_found;
    logic                    r_rd_valid, n_rd_valid;
    logic signed [ROI_W-1:0] r_rd_data;

    logic                    r_out_valid, n_out_valid;
    logic                    r_out_kind, n_out_kind;
    logic [ZONE_W-1:0]       r_out_zone, n_out_zone;
    logic [TIME_W-1:0]       r_out_time, n_out_time;

    logic                    hist_we;
    logic [IDX_W-1:0]        hist_wa;
    logic signed [ROI_W-1:0] hist_wd;
    logic                    rd_en;
    logic                    cnt_clr;
    logic                    cnt_inc;

    logic signed [ROI_W-1:0] in_vote;
    logic [IDX_W-1:0]        wp_adv;
    logic [CNT_W-1:0]        cnt_push;
    logic [7:0]              need_full;
    logic [ROI_W-1:0]        slot_full;
    logic [SLOT_W-1:0]       rd_slot;
    logic [CNT_W-1:0]        cnt_new;
    logic                    issue;
    logic signed [ROI_W-1:0] cur;
    logic                    out_free;

    always_comb begin
        in_vote = VOTE_NONE;
        if (i_is_vehicle && !i_frame_roi[ROI_W-1]
                && ({3'b000, i_frame_roi[ZONE_W-1:0]} < ZC)) begin
            in_vote = i_frame_roi;
        end
    end

    assign wp_adv    = (r_wp == WP_LAST) ? '0 : r_wp + 1'b1;
    assign cnt_push  = (r_count == DEPTH_C) ? r_count : r_count + 1'b1;
    assign need_full = div5(8'({cnt_push, 2'b00}));
    assign slot_full = r_rd_data + 5'd1;
    assign rd_slot   = slot_full[SLOT_W-1:0];
    assign cnt_new   = r_cnt[rd_slot] + 1'b1;
    assign issue     = (r_idx < r_count);
    assign cur       = r_found ? ($signed(5'(r_best)) - 5'sd1) : r_prev;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_wp        = r_wp;
        n_stable    = r_stable;
        n_notified  = r_notified;
        n_entry     = r_entry;
        n_idx       = r_idx;
        n_need      = r_need;
        n_prev      = r_prev;
        n_vehicle   = r_vehicle;
        n_now       = r_now;
        n_best      = r_best;
        n_found     = r_found;
        n_rd_valid  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_zone  = r_out_zone;
        n_out_time  = r_out_time;
        hist_we     = 1'b0;
        hist_wa     = r_wp;
        hist_wd     = VOTE_NONE;
        rd_en       = 1'b0;
        cnt_clr     = 1'b0;
        cnt_inc     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        REQ_FRAME: begin
                            hist_we   = 1'b1;
                            hist_wd   = in_vote;
                            n_wp      = wp_adv;
                            n_count   = cnt_push;
                            n_need    = need_full[CNT_W-1:0];
                            cnt_clr   = 1'b1;
                            n_idx     = '0;
                            n_found   = 1'b0;
                            n_prev    = r_stable;
                            n_vehicle = i_is_vehicle;
                            n_now     = i_now_ms;
                            n_state   = ST_SCAN;
                        end
                        REQ_NOTIFY: begin
                            n_notified = 1'b1;
                        end
                        REQ_RESET: begin
                            n_count    = '0;
                            n_wp       = '0;
                            n_stable   = VOTE_NONE;
                            n_notified = 1'b0;
                            n_entry    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read of entry idx overlaps the tally of the previous entry
                if (issue) begin
                    rd_en      = 1'b1;
                    n_idx      = r_idx + 1'b1;
                    n_rd_valid = 1'b1;
                end
                if (r_rd_valid) begin
                    cnt_inc = 1'b1;
                    // counts only grow, so a slot qualifies the moment it hits the bar
                    if (cnt_new >= r_need && (!r_found || rd_slot < r_best)) begin
                        n_found = 1'b1;
                        n_best  = rd_slot;
                    end
                end
                if (!issue && !r_rd_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_stable = cur;
                if (r_vehicle && !r_prev[ROI_W-1] && cur[ROI_W-1]) begin
                    if (!r_notified || out_free) begin
                        n_state = ST_IDLE;
                        if (r_notified) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = EV_DEPART;
                            n_out_zone  = r_prev[ZONE_W-1:0];
                            n_out_time  = r_entry;
                        end
                        n_entry    = '0;
                        n_notified = 1'b0;
                        // reseed the history with a single none vote
                        hist_we    = 1'b1;
                        hist_wa    = '0;
                        hist_wd    = VOTE_NONE;
                        n_count    = CNT_W'(1);
                        n_wp       = WP_ONE;
                    end
                end else if (r_vehicle && r_prev[ROI_W-1] && !cur[ROI_W-1]) begin
                    if (out_free) begin
                        n_state     = ST_IDLE;
                        n_entry     = r_now;
                        n_out_valid = 1'b1;
                        n_out_kind  = EV_ENTRY;
                        n_out_zone  = cur[ZONE_W-1:0];
                        n_out_time  = r_now;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_wp        <= '0;
            r_stable    <= VOTE_NONE;
            r_notified  <= 1'b0;
            r_entry     <= '0;
            r_found     <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wp        <= n_wp;
            r_stable    <= n_stable;
            r_notified  <= n_notified;
            r_entry     <= n_entry;
            r_found     <= n_found;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_need     <= n_need;
        r_prev     <= n_prev;
        r_vehicle  <= n_vehicle;
        r_now      <= n_now;
        r_best     <= n_best;
        r_out_kind <= n_out_kind;
        r_out_zone <= n_out_zone;
        r_out_time <= n_out_time;
    end

    // vote history, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[hist_wa] <= hist_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_hist[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_clr) begin
            for (int k = 0; k < NSLOT; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (cnt_inc) begin
            r_cnt[rd_slot] <= cnt_new;
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_zone_index    = r_out_zone;
    assign o_entry_time_ms = r_out_time;

`include "roi_vote_hysteresis_core_assert.svh"

    `RVH_ASSERT_NOW(a_count_bound, 1'b1, r_count <= DEPTH_C, "history count above depth")

    `RVH_ASSERT_NOW(a_read_order, (r_state == ST_SCAN) && r_rd_valid, r_idx != '0,
        "tally data without a prior read")

    `RVH_ASSERT_NEXT(a_frame_start,
        i_in_valid && o_in_ready && (i_req_type == REQ_FRAME),
        (r_state == ST_SCAN) && !r_found && !r_rd_valid && (r_count != '0),
        "frame transaction did not start a clean scan")

    `RVH_ASSERT_NOW(a_winner_bar, (r_state == ST_DECIDE) && r_found,
        (r_cnt[r_best] >= r_need) && (r_cnt[r_best] != '0),
        "chosen zone below the vote bar")

endmodule

/* bench/roi_vote_hysteresis_checker.sv */
`timescale 1ns / 100ps

module roi_vote_hysteresis_checker
    import rvh_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic signed [ROI_W-1:0] i_frame_roi,
    input  logic                    i_is_vehicle,
    input  logic [TIME_W-1:0]       i_now_ms,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_event_kind,
    input  logic [ZONE_W-1:0]       i_zone_index,
    input  logic [TIME_W-1:0]       i_entry_time_ms,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_event_count
);

    typedef struct packed {
        logic              kind;
        logic [ZONE_W-1:0] zone;
        logic [TIME_W-1:0] stamp;
    } t_zone_event;

    t_zone_event expected_events[$];

    // shadow copy of the track state
    logic signed [ROI_W-1:0] votes [RVH_HISTORY_DEPTH];
    int                      votes_held;
    logic signed [ROI_W-1:0] settled_zone;
    logic                    notified;
    logic [TIME_W-1:0]       entered_at;

    int fails;
    int events_seen;

    task clear_track();
        votes_held   = 0;
        settled_zone = VOTE_NONE;
        notified     = 1'b0;
        entered_at   = '0;
    endtask

    // full history drops the oldest vote first
    task push_ballot(input logic signed [ROI_W-1:0] ballot);
        if (votes_held >= RVH_HISTORY_DEPTH) begin
            for (int i = 0; i < RVH_HISTORY_DEPTH - 1; i++)
                votes[i] = votes[i + 1];
            votes[RVH_HISTORY_DEPTH - 1] = ballot;
        end else begin
            votes[votes_held] = ballot;
            votes_held++;
        end
    endtask

    task predict_zone_event(input logic [1:0] req, input logic signed [ROI_W-1:0] roi,
                            input logic vehicle, input logic [TIME_W-1:0] stamp);
        logic signed [ROI_W-1:0] ballot;
        logic signed [ROI_W-1:0] was_zone;
        logic signed [ROI_W-1:0] now_zone;
        int                      tally [RVH_ZONE_COUNT + 1];
        int                      need;
        case (req)
            REQ_NOTIFY: notified = 1'b1;
            REQ_RESET:  clear_track();
            REQ_FRAME: begin
                ballot = (vehicle && roi >= 0 && int'(roi) < RVH_ZONE_COUNT) ? roi : VOTE_NONE;
                was_zone = settled_zone;
                push_ballot(ballot);
                foreach (tally[i]) tally[i] = 0;
                for (int i = 0; i < votes_held; i++) begin
                    if (votes[i] >= 0 && int'(votes[i]) < RVH_ZONE_COUNT)
                        tally[int'(votes[i]) + 1]++;
                    else
                        tally[0]++;
                end
                need = votes_held * 4 / 5;
                // walk downwards so the smallest qualifying index wins, none first
                now_zone = was_zone;
                for (int i = RVH_ZONE_COUNT; i >= 0; i--) begin
                    if (tally[i] > 0 && tally[i] >= need)
                        now_zone = ROI_W'(i - 1);
                end
                settled_zone = now_zone;
                if (vehicle && was_zone >= 0 && now_zone < 0) begin
                    if (notified)
                        expected_events.push_back(
                            t_zone_event'{EV_DEPART, ZONE_W'(was_zone), entered_at});
                    // departure clears the track even when nothing is reported
                    entered_at = '0;
                    notified   = 1'b0;
                    votes_held = 0;
                    push_ballot(VOTE_NONE);
                end else if (vehicle && was_zone < 0 && now_zone >= 0) begin
                    entered_at = stamp;
                    expected_events.push_back(t_zone_event'{EV_ENTRY, ZONE_W'(now_zone), stamp});
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_zone_event due;
        if (!i_rst_n) begin
            clear_track();
            expected_events.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_zone_event(i_req_type, i_frame_roi, i_is_vehicle, i_now_ms);
            if (i_out_valid && i_out_ready) begin
                events_seen++;
                if (expected_events.size() == 0) begin
                    $error("unexpected event: event_kind %0d zone_index %0d entry_time_ms %0d",
                           i_event_kind, i_zone_index, i_entry_time_ms);
                    fails++;
                end else begin
                    due = expected_events.pop_front();
                    if (i_event_kind !== due.kind) begin
                        $error("event_kind: expected %0d, actual %0d", due.kind, i_event_kind);
                        fails++;
                    end
                    if (i_zone_index !== due.zone) begin
                        $error("zone_index: expected %0d, actual %0d", due.zone, i_zone_index);
                        fails++;
                    end
                    if (i_entry_time_ms !== due.stamp) begin
                        $error("entry_time_ms: expected %0d, actual %0d",
                               due.stamp, i_entry_time_ms);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_pending     <= expected_events.size();
        o_event_count <= events_seen;
    end

endmodule

/* bench/roi_vote_hysteresis_core_test.sv */
`timescale 1ns / 100ps

module roi_vote_hysteresis_core_test;
    import rvh_pkg::*;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    in_valid      = 1'b0;
    logic                    in_ready;
    logic [1:0]              req_type      = REQ_FRAME;
    logic signed [ROI_W-1:0] frame_roi     = VOTE_NONE;
    logic                    is_vehicle    = 1'b0;
    logic [TIME_W-1:0]       now_ms        = '0;
    logic                    out_valid;
    logic                    out_ready     = 1'b0;
    logic                    event_kind;
    logic [ZONE_W-1:0]       zone_index;
    logic [TIME_W-1:0]       entry_time_ms;

    int fail_count;
    int events_pending;
    int events_checked;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int requests_sent      = 0;

    always #2 clk = ~clk;

    roi_vote_hysteresis_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_frame_roi     (frame_roi),
        .i_is_vehicle    (is_vehicle),
        .i_now_ms        (now_ms),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_event_kind    (event_kind),
        .o_zone_index    (zone_index),
        .o_entry_time_ms (entry_time_ms)
    );

    roi_vote_hysteresis_checker zone_event_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_frame_roi     (frame_roi),
        .i_is_vehicle    (is_vehicle),
        .i_now_ms        (now_ms),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_event_kind    (event_kind),
        .i_zone_index    (zone_index),
        .i_entry_time_ms (entry_time_ms),
        .o_fail_count    (fail_count),
        .o_pending       (events_pending),
        .o_event_count   (events_checked)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    function automatic logic [TIME_W-1:0] any_stamp();
        return {16'($urandom), $urandom};
    endfunction

    // called at a clock edge, returns at the edge where the transaction is taken
    task send_request(input logic [1:0] req, input logic signed [ROI_W-1:0] roi,
                      input logic vehicle, input logic [TIME_W-1:0] stamp);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        frame_roi  <= roi;
        is_vehicle <= vehicle;
        now_ms     <= stamp;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    // hold the sender off until every predicted event has been taken
    task drain_events();
        in_valid <= 1'b0;
        do @(posedge clk); while (events_pending != 0);
        repeat (40) @(posedge clk);
    endtask

    task send_noise_frame();
        send_request(REQ_FRAME, ROI_W'($urandom_range(31)), 1'($urandom_range(1)), any_stamp());
    endtask

    // dwell in one zone, maybe get notified, then lose the zone
    task run_traffic(input int quota);
        int target;
        int zone;
        int dwell;
        int gone;
        int pick;
        target = requests_sent + quota;
        while (requests_sent < target) begin
            if ($urandom_range(99) < 15) begin
                send_request(2'($urandom_range(3)), ROI_W'($urandom_range(31)),
                             1'($urandom_range(1)), any_stamp());
            end else begin
                zone  = $urandom_range(RVH_ZONE_COUNT - 1);
                dwell = $urandom_range(1, 14);
                repeat (dwell) begin
                    if ($urandom_range(99) < 85)
                        send_request(REQ_FRAME, ROI_W'(zone), 1'b1, any_stamp());
                    else
                        send_noise_frame();
                end
                if ($urandom_range(99) < 70)
                    send_request(REQ_NOTIFY, ROI_W'($urandom_range(31)),
                                 1'($urandom_range(1)), any_stamp());
                gone = $urandom_range(2, 16);
                repeat (gone) begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        send_request(REQ_FRAME, VOTE_NONE, 1'b1, any_stamp());
                    else if (pick < 70)
                        send_request(REQ_FRAME, ROI_W'($urandom_range(16, 31)), 1'b1,
                                     any_stamp());
                    else if (pick < 85)
                        send_request(REQ_FRAME, ROI_W'($urandom_range(31)), 1'b0, any_stamp());
                    else
                        send_noise_frame();
                end
                if ($urandom_range(99) < 10)
                    send_request(REQ_RESET, ROI_W'($urandom_range(31)),
                                 1'($urandom_range(1)), any_stamp());
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single vote settles at once, entry at time zero
        send_request(REQ_FRAME, ROI_W'(0), 1'b1, '0);
        send_request(REQ_NOTIFY, VOTE_NONE, 1'b0, '0);
        // notified departure carries the stored entry time
        send_request(REQ_FRAME, VOTE_NONE, 1'b1, '1);
        send_request(REQ_FRAME, ROI_W'(ROI_MAX), 1'b1, '1);
        send_request(REQ_FRAME, ROI_W'(ROI_MAX), 1'b1, '1);
        // non-vehicle votes none but raises nothing
        send_request(REQ_FRAME, ROI_W'(ROI_MAX), 1'b0, '0);
        // negative zones count as none
        send_request(REQ_FRAME, -5'sd16, 1'b1, 48'h5555_5555_5555);
        // departure without the notified mark stays silent
        send_request(REQ_FRAME, -5'sd2, 1'b1, 48'hAAAA_AAAA_AAAA);
        send_request(REQ_RESET, ROI_W'(ROI_MAX), 1'b1, '1);
        send_request(2'd3, ROI_W'(7), 1'b1, '1);
        // fill the history past its depth
        repeat (RVH_HISTORY_DEPTH + 1)
            send_request(REQ_FRAME, ROI_W'(7), 1'b1, any_stamp());
        drain_events();

        sender_idle_pct = 0;  receiver_stall_pct = 0;
        run_traffic(256);
        drain_events();
        sender_idle_pct = 59; receiver_stall_pct = 0;
        run_traffic(256);
        drain_events();
        sender_idle_pct = 0;  receiver_stall_pct = 59;
        run_traffic(256);
        drain_events();
        sender_idle_pct = 35; receiver_stall_pct = 35;
        run_traffic(256);
        drain_events();

        $display("%0d requests sent over four idle and stall mixes, %0d zone events compared",
                 requests_sent, events_checked);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* roi_vote_hysteresis_core.f */
+incdir+rtl
rtl/rvh_pkg.sv
rtl/roi_vote_hysteresis_core.sv
bench/roi_vote_hysteresis_checker.sv
bench/roi_vote_hysteresis_core_test.sv
